### rtl/fdl_pkg.sv
`timescale 1ns / 1ps
// shared types, field widths and constants of the fractional delay line
// no dependencies

package fdl_pkg;

   localparam int CMD_W    = 3;
   localparam int SAMPLE_W = 24;
   localparam int DELAY_W  = 32;
   localparam int FRAC_W   = 16;
   localparam int INT_W    = 16;
   localparam int ACC_W    = 32;
   localparam int PROD_W   = ACC_W + FRAC_W + 1;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE     = 3'd0,
      CMD_READ_CFG  = 3'd1,
      CMD_READ_HERM = 3'd2,
      CMD_READ_NEAR = 3'd3,
      CMD_READ_LIN  = 3'd4
   } cmd_type;

   localparam logic [DELAY_W-1:0] HALF_Q16    = 32'h0000_8000;
   localparam logic [DELAY_W-1:0] ONE_Q16     = 32'h0001_0000;
   localparam logic [DELAY_W-1:0] TWO_Q16     = 32'h0002_0000;
   localparam logic [DELAY_W-1:0] DELAY_RESET = 32'h0002_0000;

   localparam logic signed [ACC_W-1:0] SAT_HI = 32'sd8388607;
   localparam logic signed [ACC_W-1:0] SAT_LO = -32'sd8388608;
   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

   function automatic logic signed [SAMPLE_W-1:0] sat_sample(
      input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI;
      end else if (v < SAT_LO) begin
         r = SAT_LO;
      end else begin
         r = v;
      end
      return r[SAMPLE_W-1:0];
   endfunction

endpackage

### rtl/fdl_ram.sv
`timescale 1ns / 1ps
// generic memory, one write port and one read port with registered read data
// no dependencies

module fdl_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/fractional_delay_line.sv
`timescale 1ns / 1ps
// fractional delay line top level: sample store, tap sequencer, shared multiplier
// depends on fdl_pkg and fdl_ram
//
// usage:
//   req_ channel carries one item: cmd, sample_in, delay_in. a write stores
//   sample_in and gives no result; reads give one rsp_sample_out item.
//   csr_write_en / csr_write_data set the configured delay (Q16.16).
//   a write or an unused cmd leaves the sequencer idle and req_ready stays high.
//   reads fetch their taps one per cycle from a single memory read port,
//   then run the multiply / round-accumulate steps on one shared 32x17
//   multiplier (linear and hermite reads only). req_ready is low while a
//   read is in progress.
//   the result sits in an output register; the next item is taken while it
//   waits, and a finished read holds until rsp_ready frees the register.
//   reset empties the store at once: a fill count of writes marks which
//   entries hold data, and never-written taps read as zero. no clearing pass.
//   reset sets the configured delay to 2.0.

module fractional_delay_line #(
   parameter int DEPTH = 65536
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [fdl_pkg::CMD_W-1:0]             req_cmd,
   input  logic signed [fdl_pkg::SAMPLE_W-1:0]   req_sample_in,
   input  logic [fdl_pkg::DELAY_W-1:0]           req_delay_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [fdl_pkg::SAMPLE_W-1:0]   rsp_sample_out,
   input  logic                                  csr_write_en,
   input  logic [fdl_pkg::DELAY_W-1:0]           csr_write_data
);

   import fdl_pkg::*;

   localparam int AW      = $clog2(DEPTH);
   localparam int CLAMP_W = 25;
   localparam logic [CLAMP_W-1:0] LIM1 = CLAMP_W'(DEPTH - 1);
   localparam logic [CLAMP_W-1:0] LIM2 = CLAMP_W'(DEPTH - 2);
   localparam logic [CLAMP_W-1:0] LIM3 = CLAMP_W'(DEPTH - 3);
   localparam logic [AW:0]        DEPTH_EXT = (AW + 1)'(DEPTH);
   localparam logic [1:0]         LAST_STEP = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_CAPT, ST_PREP, ST_MUL, ST_ACC, ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      MODE_TAP, MODE_LIN, MODE_HERM
   } mode_type;

   function automatic logic [AW-1:0] clamp_int(input logic [INT_W:0] v,
                                               input logic [CLAMP_W-1:0] lim);
      logic [CLAMP_W-1:0] ext;
      logic [CLAMP_W-1:0] r;
      ext = CLAMP_W'(v);
      r = (ext > lim) ? lim : ext;
      return r[AW-1:0];
   endfunction

   state_type state_ff, state_in;
   mode_type  mode_ff, mode_in;
   logic [AW-1:0] wp_ff, wp_in;
   logic [AW-1:0] fill_ff, fill_in;
   logic [AW-1:0] dly_ff, dly_in;
   logic [1:0]    left_ff, left_in;
   logic [1:0]    idx_ff, idx_in;
   logic [FRAC_W-1:0] t_ff, t_in;
   logic          cap_en_ff, cap_en_in;
   logic [1:0]    cap_idx_ff, cap_idx_in;
   logic          cap_hit_ff, cap_hit_in;
   logic signed [SAMPLE_W-1:0] tap_ff [4];
   logic signed [SAMPLE_W-1:0] tap_in [4];
   logic signed [ACC_W-1:0]  c1_ff, c1_in, c2_ff, c2_in, a_ff, a_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [1:0]    step_ff, step_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic [DELAY_W-1:0] setting_ff, setting_in;

   logic accept;
   logic [DELAY_W-1:0] dsel, d_min1, d_min2;
   logic [DELAY_W:0]   near_sum;
   logic [AW-1:0] i_herm, i_exact, i_lin, i_near;
   logic [AW:0]   addr_sum, addr_wrap;
   logic [AW-1:0] rd_addr;
   logic          rd_en, wr_en;
   logic [SAMPLE_W-1:0] rd_data;
   logic signed [FRAC_W:0]  t_s;
   logic signed [PROD_W-1:0] rnd;
   logic signed [ACC_W-1:0]  addend;
   logic signed [ACC_W-1:0]  xm1, x0, x1, x2;

   fdl_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (req_sample_in),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready      = (state_ff == ST_IDLE);
   assign accept         = req_valid && req_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

   assign dsel     = (req_cmd == CMD_READ_CFG) ? setting_ff : req_delay_in;
   assign d_min2   = (dsel < TWO_Q16) ? TWO_Q16 : dsel;
   assign d_min1   = (dsel < ONE_Q16) ? ONE_Q16 : dsel;
   assign near_sum = {1'b0, d_min1} + {1'b0, HALF_Q16};
   assign i_herm   = clamp_int({1'b0, d_min2[DELAY_W-1:FRAC_W]}, LIM3);
   assign i_exact  = clamp_int({1'b0, d_min2[DELAY_W-1:FRAC_W]}, LIM1);
   assign i_lin    = clamp_int({1'b0, d_min1[DELAY_W-1:FRAC_W]}, LIM2);
   assign i_near   = clamp_int(near_sum[DELAY_W:FRAC_W], LIM1);

   assign addr_sum  = {1'b0, wp_ff} + {1'b0, dly_ff};
   assign addr_wrap = addr_sum - DEPTH_EXT;
   assign rd_addr   = (addr_sum >= DEPTH_EXT) ? addr_wrap[AW-1:0] : addr_sum[AW-1:0];

   assign xm1 = ACC_W'(tap_ff[0]);
   assign x0  = ACC_W'(tap_ff[1]);
   assign x1  = ACC_W'(tap_ff[2]);
   assign x2  = ACC_W'(tap_ff[3]);

   assign t_s = $signed({1'b0, t_ff});
   assign rnd = prod_ff + ROUND_HALF;

   always_comb begin
      case (step_ff)
         2'd0:    addend = c2_ff;
         2'd1:    addend = c1_ff;
         default: addend = (x0 <<< 1) + ACC_W'(1);
      endcase
      if (mode_ff == MODE_LIN) begin
         addend = xm1;
      end
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      wp_in         = wp_ff;
      fill_in       = fill_ff;
      dly_in        = dly_ff;
      left_in       = left_ff;
      idx_in        = idx_ff;
      t_in          = t_ff;
      cap_en_in     = 1'b0;
      cap_idx_in    = cap_idx_ff;
      cap_hit_in    = cap_hit_ff;
      tap_in        = tap_ff;
      c1_in         = c1_ff;
      c2_in         = c2_ff;
      a_in          = a_ff;
      prod_in       = prod_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_sample_in = rsp_sample_ff;
      setting_in    = csr_write_en ? csr_write_data : setting_ff;
      rd_en         = 1'b0;
      wr_en         = 1'b0;

      if (cap_en_ff) begin
         tap_in[cap_idx_ff] = cap_hit_ff ? $signed(rd_data) : '0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            idx_in = 2'd0;
            if (accept) begin
               unique case (req_cmd)
                  CMD_WRITE: begin
                     wr_en   = 1'b1;
                     wp_in   = (wp_ff == '0) ? LIM1[AW-1:0] : wp_ff - 1'b1;
                     fill_in = (fill_ff == LIM1[AW-1:0]) ? fill_ff : fill_ff + 1'b1;
                  end
                  CMD_READ_CFG: begin
                     state_in = ST_READ;
                     if (d_min2[FRAC_W-1:0] == '0) begin
                        mode_in = MODE_TAP;
                        dly_in  = i_exact;
                        left_in = 2'd0;
                     end else begin
                        mode_in = MODE_HERM;
                        dly_in  = i_herm - 1'b1;
                        left_in = 2'd3;
                        t_in    = d_min2[FRAC_W-1:0];
                     end
                  end
                  CMD_READ_HERM: begin
                     state_in = ST_READ;
                     mode_in  = MODE_HERM;
                     dly_in   = i_herm - 1'b1;
                     left_in  = 2'd3;
                     t_in     = d_min2[FRAC_W-1:0];
                  end
                  CMD_READ_NEAR: begin
                     state_in = ST_READ;
                     mode_in  = MODE_TAP;
                     dly_in   = i_near;
                     left_in  = 2'd0;
                  end
                  CMD_READ_LIN: begin
                     state_in = ST_READ;
                     mode_in  = MODE_LIN;
                     dly_in   = i_lin;
                     left_in  = 2'd1;
                     t_in     = d_min1[FRAC_W-1:0];
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            rd_en      = 1'b1;
            cap_en_in  = 1'b1;
            cap_idx_in = idx_ff;
            cap_hit_in = (dly_ff <= fill_ff);
            dly_in     = dly_ff + 1'b1;
            idx_in     = idx_ff + 1'b1;
            if (idx_ff == left_ff) begin
               state_in = ST_CAPT;
            end
         end
         ST_CAPT: begin
            state_in = ST_PREP;
         end
         ST_PREP: begin
            unique case (mode_ff)
               MODE_LIN: begin
                  a_in     = x0 - xm1;
                  step_in  = LAST_STEP;
                  state_in = ST_MUL;
               end
               MODE_HERM: begin
                  c1_in    = x1 - xm1;
                  c2_in    = (xm1 <<< 1) - ((x0 <<< 2) + x0) + (x1 <<< 2) - x2;
                  a_in     = (x2 - xm1) + ((x0 - x1) <<< 1) + (x0 - x1);
                  step_in  = 2'd0;
                  state_in = ST_MUL;
               end
               default: begin
                  a_in     = xm1;
                  state_in = ST_OUT;
               end
            endcase
         end
         ST_MUL: begin
            prod_in  = a_ff * t_s;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            a_in    = $signed(rnd[PROD_W-2:FRAC_W]) + addend;
            step_in = step_ff + 1'b1;
            state_in = (step_ff == LAST_STEP) ? ST_OUT : ST_MUL;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = sat_sample((mode_ff == MODE_HERM) ? (a_ff >>> 1) : a_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         fill_ff      <= '0;
         cap_en_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         setting_ff   <= DELAY_RESET;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         cap_en_ff    <= cap_en_in;
         rsp_valid_ff <= rsp_valid_in;
         setting_ff   <= setting_in;
      end
      mode_ff       <= mode_in;
      dly_ff        <= dly_in;
      left_ff       <= left_in;
      idx_ff        <= idx_in;
      t_ff          <= t_in;
      cap_idx_ff    <= cap_idx_in;
      cap_hit_ff    <= cap_hit_in;
      tap_ff        <= tap_in;
      c1_ff         <= c1_in;
      c2_ff         <= c2_in;
      a_ff          <= a_in;
      prod_ff       <= prod_in;
      step_ff       <= step_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   // a finished read with a free output register is delivered next cycle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready)
      |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("finished read not delivered");

   // tap capture only follows a memory read
   assert property (@(posedge clock) disable iff (reset)
      cap_en_ff |-> (state_ff == ST_READ) || (state_ff == ST_CAPT))
      else $error("tap capture outside read sequence");

   // tap delays never reach the store depth
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> ({1'b0, dly_ff} < DEPTH_EXT) && (dly_ff != '0))
      else $error("tap delay out of range");

endmodule

### bench/fractional_delay_line_tb.sv
`timescale 1ns / 1ps
// self-checking bench for fractional_delay_line: random and directed items, scoreboard class
// depends on fdl_pkg and the fractional_delay_line rtl

module fractional_delay_line_tb;

   import fdl_pkg::*;

   localparam int DEPTH          = 65536;
   localparam int SETTLE_CYCLES  = 24;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 4000;

   class delay_scoreboard;
      logic signed [SAMPLE_W-1:0] store [DEPTH];
      int unsigned                wr_pos;
      logic [DELAY_W-1:0]         delay_cfg;
      logic signed [SAMPLE_W-1:0] expected_samples [$];
      int errors;
      int writes;
      int ignored;
      int cfg_writes;
      int results_seen;
      int reads_by_kind [8];

      function new();
         foreach (store[k]) store[k] = '0;
         foreach (reads_by_kind[k]) reads_by_kind[k] = 0;
         wr_pos       = 0;
         delay_cfg    = DELAY_RESET;
         errors       = 0;
         writes       = 0;
         ignored      = 0;
         cfg_writes   = 0;
         results_seen = 0;
      endfunction

      function int pending();
         return expected_samples.size();
      endfunction

      function void set_delay(logic [DELAY_W-1:0] v);
         delay_cfg = v;
         cfg_writes++;
      endfunction

      // sample written d writes ago
      function longint tap(int unsigned d);
         return longint'(store[(wr_pos + d % DEPTH) % DEPTH]);
      endfunction

      function longint round_q16(longint v);
         return (v + 32768) >>> FRAC_W;
      endfunction

      function logic signed [SAMPLE_W-1:0] saturate(longint v);
         if (v > SAT_HI) return SAT_HI[SAMPLE_W-1:0];
         if (v < SAT_LO) return SAT_LO[SAMPLE_W-1:0];
         return v[SAMPLE_W-1:0];
      endfunction

      function logic signed [SAMPLE_W-1:0] hermite(int unsigned i, longint t);
         longint xm1, x0, x1, x2, c1, c2, c3, acc;
         xm1 = tap(i - 1);
         x0  = tap(i);
         x1  = tap(i + 1);
         x2  = tap(i + 2);
         c1  = x1 - xm1;
         c2  = 2 * xm1 - 5 * x0 + 4 * x1 - x2;
         c3  = (x2 - xm1) + 3 * (x0 - x1);
         acc = c3;
         acc = round_q16(acc * t) + c2;
         acc = round_q16(acc * t) + c1;
         acc = round_q16(acc * t);
         return saturate((acc + 2 * x0 + 1) >>> 1);
      endfunction

      function logic signed [SAMPLE_W-1:0] read_configured();
         logic [DELAY_W-1:0] d;
         int unsigned        ip;
         longint             f;
         d  = (delay_cfg < TWO_Q16) ? TWO_Q16 : delay_cfg;
         ip = d >> FRAC_W;
         f  = longint'(d[FRAC_W-1:0]);
         if (f == 0) begin
            if (ip > DEPTH - 1) ip = DEPTH - 1;
            return saturate(tap(ip));
         end
         if (ip > DEPTH - 3) ip = DEPTH - 3;
         return hermite(ip, f);
      endfunction

      function logic signed [SAMPLE_W-1:0] read_hermite(logic [DELAY_W-1:0] dly);
         logic [DELAY_W-1:0] d;
         int unsigned        ip;
         d  = (dly < TWO_Q16) ? TWO_Q16 : dly;
         ip = d >> FRAC_W;
         if (ip > DEPTH - 3) ip = DEPTH - 3;
         return hermite(ip, longint'(d[FRAC_W-1:0]));
      endfunction

      function logic signed [SAMPLE_W-1:0] read_nearest(logic [DELAY_W-1:0] dly);
         logic [DELAY_W-1:0] d;
         logic [DELAY_W:0]   r;
         int unsigned        ip;
         d  = (dly < ONE_Q16) ? ONE_Q16 : dly;
         r  = {1'b0, d} + {1'b0, HALF_Q16};
         ip = int'(r >> FRAC_W);
         if (ip > DEPTH - 1) ip = DEPTH - 1;
         return saturate(tap(ip));
      endfunction

      function logic signed [SAMPLE_W-1:0] read_linear(logic [DELAY_W-1:0] dly);
         logic [DELAY_W-1:0] d;
         int unsigned        ip;
         longint             x0, x1;
         d  = (dly < ONE_Q16) ? ONE_Q16 : dly;
         ip = d >> FRAC_W;
         if (ip > DEPTH - 2) ip = DEPTH - 2;
         x0 = tap(ip);
         x1 = tap(ip + 1);
         return saturate(x0 + round_q16((x1 - x0) * longint'(d[FRAC_W-1:0])));
      endfunction

      function void note_item(logic [CMD_W-1:0] cmd, logic signed [SAMPLE_W-1:0] smp,
                              logic [DELAY_W-1:0] dly);
         case (cmd)
            CMD_WRITE: begin
               store[wr_pos] = smp;
               wr_pos = (wr_pos == 0) ? DEPTH - 1 : wr_pos - 1;
               writes++;
            end
            CMD_READ_CFG:  expected_samples.push_back(read_configured());
            CMD_READ_HERM: expected_samples.push_back(read_hermite(dly));
            CMD_READ_NEAR: expected_samples.push_back(read_nearest(dly));
            CMD_READ_LIN:  expected_samples.push_back(read_linear(dly));
            default:       ignored++;
         endcase
         if (cmd >= CMD_READ_CFG && cmd <= CMD_READ_LIN) reads_by_kind[cmd]++;
      endfunction

      function void check_result(logic signed [SAMPLE_W-1:0] actual);
         logic signed [SAMPLE_W-1:0] want;
         if (expected_samples.size() == 0) begin
            $error("sample_out: no read waiting, actual %0d", actual);
            errors++;
            return;
         end
         want = expected_samples.pop_front();
         results_seen++;
         if (actual !== want) begin
            $error("sample_out mismatch: expected %0d, actual %0d", want, actual);
            errors++;
         end
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [CMD_W-1:0]            req_cmd = '0;
   logic signed [SAMPLE_W-1:0]  req_sample_in = '0;
   logic [DELAY_W-1:0]          req_delay_in = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0]  rsp_sample_out;
   logic                        csr_write_en = 1'b0;
   logic [DELAY_W-1:0]          csr_write_data = '0;

   delay_scoreboard sb = new();

   int burst_left = 0;
   int burst_max  = 40;
   int gap_max    = 12;
   int stall_cycles = 0;
   int hold_count = 0;

   fractional_delay_line #(.DEPTH(DEPTH)) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_sample_in  (req_sample_in),
      .req_delay_in   (req_delay_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_result(rsp_sample_out);
         if (req_valid && req_ready) sb.note_item(req_cmd, req_sample_in, req_delay_in);
         if (csr_write_en) sb.set_delay(csr_write_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_en) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", stall_cycles);
         $display("DONE: errors detected");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // receiver: random stretches of full rate, random and periodic stalls, two long hold-offs
   initial begin : receiver
      int seg;
      int mode;
      int k;
      int hold_at;
      hold_at = 150;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_count < 2 && sb.results_seen >= hold_at) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_count++;
            hold_at = 700;
         end
         seg  = $urandom_range(1, 60);
         mode = $urandom_range(0, 2);
         for (k = 0; k < seg; k++) begin
            case (mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= ($urandom_range(0, 9) < 7);
               default: rsp_ready <= (k % 3 != 2);
            endcase
            @(posedge clock);
         end
      end
   end

   function automatic logic signed [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(0, 4))
         0:       return 24'sh7FFFFF;
         1:       return 24'sh800000;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic logic [DELAY_W-1:0] rand_delay(bit far);
      logic [INT_W-1:0]  ip;
      logic [FRAC_W-1:0] fp;
      int                sel;
      sel = $urandom_range(0, 99);
      case ($urandom_range(0, 6))
         0:       fp = '0;
         1:       fp = 16'h8000;
         2:       fp = 16'h7FFF;
         3:       fp = 16'hFFFF;
         4:       fp = 16'h0001;
         default: fp = FRAC_W'($urandom);
      endcase
      if (sel < 15) return $urandom;
      if (sel < 22) ip = INT_W'($urandom_range(0, 2));
      else if (sel < 29) ip = INT_W'($urandom_range(DEPTH - 3, DEPTH - 1));
      else if (sel < 37) ip = INT_W'($urandom);
      else if (far) ip = INT_W'($urandom_range(DEPTH - 140, DEPTH - 1));
      else ip = INT_W'($urandom_range(0, 48));
      return {ip, fp};
   endfunction

   task automatic drive_item(logic [CMD_W-1:0] c, logic signed [SAMPLE_W-1:0] s,
                             logic [DELAY_W-1:0] d);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         gap = $urandom_range(1, gap_max);
         burst_left = $urandom_range(1, burst_max);
      end else begin
         burst_left--;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= c;
      req_sample_in <= s;
      req_delay_in  <= d;
      do @(posedge clock); while (!req_ready);
   endtask

   // wait for every read to come back, then for the block to go quiet
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [DELAY_W-1:0] v);
      csr_write_en   <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_en   <= 1'b0;
   endtask

   task automatic random_items(int n, bit far);
      int               done_n;
      int               sel;
      logic [CMD_W-1:0] c;
      done_n = 0;
      while (done_n < n) begin
         sel = $urandom_range(0, 99);
         if (sel < 45) c = CMD_WRITE;
         else if (sel < 57) c = CMD_READ_CFG;
         else if (sel < 70) c = CMD_READ_HERM;
         else if (sel < 83) c = CMD_READ_NEAR;
         else if (sel < 95) c = CMD_READ_LIN;
         else c = CMD_W'($urandom_range(5, 7));
         drive_item(c, rand_sample(), rand_delay(far));
         if (c <= CMD_READ_LIN) done_n++;
      end
   endtask

   task automatic directed_items();
      drive_item(CMD_READ_CFG,  24'sh000000, 32'h0000_0000);   // empty store
      drive_item(CMD_WRITE,     24'sh7FFFFF, 32'hFFFF_FFFF);
      drive_item(CMD_WRITE,     24'sh800000, 32'h0000_0000);
      drive_item(CMD_WRITE,     24'sh7FFFFF, 32'hFFFF_FFFF);
      drive_item(CMD_WRITE,     24'sh800000, 32'h0000_0000);
      drive_item(CMD_WRITE,     24'sh7FFFFF, 32'hFFFF_FFFF);
      drive_item(CMD_WRITE,     24'sh000001, 32'h0000_0000);
      drive_item(CMD_WRITE,     24'shFFFFFF, 32'hFFFF_FFFF);
      drive_item(CMD_READ_CFG,  24'sh7FFFFF, 32'hFFFF_FFFF);   // reset delay, exact
      drive_item(CMD_READ_HERM, 24'sh000000, 32'h0000_0000);   // below minimum
      drive_item(CMD_READ_HERM, 24'sh000000, 32'h0002_8000);
      drive_item(CMD_READ_HERM, 24'sh000000, 32'h0003_8000);   // overshoot between extremes
      drive_item(CMD_READ_HERM, 24'sh000000, 32'hFFFF_FFFF);   // integer part clamped
      drive_item(CMD_READ_NEAR, 24'sh000000, 32'h0000_0000);
      drive_item(CMD_READ_NEAR, 24'sh000000, 32'h0001_7FFF);
      drive_item(CMD_READ_NEAR, 24'sh000000, 32'h0001_8000);   // half rounds up
      drive_item(CMD_READ_NEAR, 24'sh000000, 32'hFFFF_FFFF);   // rounding past the top
      drive_item(CMD_READ_LIN,  24'sh000000, 32'h0000_0000);
      drive_item(CMD_READ_LIN,  24'sh000000, 32'h0002_4000);
      drive_item(CMD_READ_LIN,  24'sh000000, 32'h0003_FFFF);
      drive_item(CMD_READ_LIN,  24'sh000000, 32'hFFFF_FFFF);
      drive_item(3'd5,          24'sh7FFFFF, 32'hFFFF_FFFF);   // unused commands
      drive_item(3'd6,          24'sh000000, 32'h0000_0000);
      drive_item(3'd7,          24'sh7FFFFF, 32'hFFFF_FFFF);
      drive_item(CMD_READ_NEAR, 24'sh000000, 32'h0002_0000);
   endtask

   initial begin : stimulus
      logic [DELAY_W-1:0] cfg_list [10];
      int                 k;
      cfg_list = '{32'h0000_0000, 32'h0001_FFFF, 32'h0002_0000, 32'h0003_8000,
                   32'h0005_0001, 32'hFFFF_0000, 32'hFFFF_FFFF, 32'h0000_FFFF,
                   32'h0000_0000, 32'h0000_0000};
      cfg_list[8] = {16'($urandom_range(2, 40)), 16'($urandom)};
      cfg_list[9] = $urandom;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed_items();
      for (k = 0; k < 10; k++) begin
         settle();
         csr_write(cfg_list[k]);
         random_items(160, 1'b0);
      end

      settle();
      csr_write(32'hFFFF_0000);
      random_items(60, 1'b1);
      settle();
      csr_write(32'hFFFD_8000);
      random_items(60, 1'b1);
      settle();
      csr_write(32'hFFFF_FFFF);
      random_items(60, 1'b1);
      settle();

      $display("covered %0d writes, %0d ignored commands, %0d delay settings",
               sb.writes, sb.ignored, sb.cfg_writes);
      $display("reads: %0d configured, %0d hermite, %0d nearest, %0d linear; %0d long hold-offs",
               sb.reads_by_kind[CMD_READ_CFG], sb.reads_by_kind[CMD_READ_HERM],
               sb.reads_by_kind[CMD_READ_NEAR], sb.reads_by_kind[CMD_READ_LIN], hold_count);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
